/* rtl/ghalloc_pkg.sv */
// shared types and constants of the generational handle allocator
package ghalloc_pkg;

  localparam int unsigned VER_W      = 32;
  localparam int unsigned HANDLE_W   = 64;
  localparam int unsigned COMP_W     = 5;
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [VER_W-1:0] DEAD_VERSION = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE  = 3'd0,
    REQ_DESTROY = 3'd1,
    REQ_CHECK   = 3'd2,
    REQ_ADD     = 3'd3,
    REQ_REMOVE  = 3'd4,
    REQ_HAS     = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

endpackage

/* rtl/generational_handle_allocator_top.sv */
// generational handle allocator: slot tables, free stack and request sequencer
//
// channel  direction  handshake               payload
// in_      slave      in_tvalid / in_tready   tuser req_type, tdata handle, component_slot
// out_     master     out_tvalid / out_tready tdata new_handle, answer, status
//
// each request runs in two steps: a synchronous read of the slot table and free stack
// memories on transfer, then an update of them and a load of the result register.
// the next request is taken only after the write-back, so reads never see a
// pending write to the same entry.
// reset clears the state machine, the free count, the fresh slot counter and the
// output valid; the memories hold nothing meaningful until written.
// a stalled result holds the block in its update step until the result is taken.
module generational_handle_allocator_top #(
  parameter int unsigned SLOTS           = 1024,
  parameter int unsigned COMPONENT_KINDS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ghalloc_pkg::REQ_W-1:0]      in_tuser,   // req_type
  input  logic [ghalloc_pkg::IN_DATA_W-1:0]  in_tdata,   // handle, component_slot, pad
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ghalloc_pkg::OUT_DATA_W-1:0] out_tdata   // new_handle, answer, status, pad
);
  import ghalloc_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned KW = COMPONENT_KINDS;
  localparam int unsigned SW = IW + VER_W;
  localparam int unsigned TW = KW + VER_W;

  // slot table (mask above version) and free stack
  logic [TW-1:0] slot_tab   [SLOTS];
  logic [SW-1:0] free_stack [SLOTS];

  state_t state_r, state_nxt;
  logic [REQ_W-1:0]    req_r;
  logic [HANDLE_W-1:0] hdl_r;
  logic [COMP_W-1:0]   comp_r;
  logic [CW-1:0]       free_cnt_r, free_cnt_nxt;
  logic [CW-1:0]       fresh_r, fresh_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic                out_answer_r, out_answer_nxt;
  logic [1:0]          out_status_r, out_status_nxt;

  logic [TW-1:0]    tab_rd_r;
  logic [VER_W-1:0] ver_rd;
  logic [KW-1:0]    mask_rd;
  logic [SW-1:0]    stk_rd_r;

  logic          accept;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] stk_raddr;

  logic             tab_we, stk_we;
  logic [IW-1:0]    tab_waddr, stk_waddr;
  logic [VER_W-1:0] ver_wdata;
  logic [KW-1:0]    mask_wdata;
  logic [SW-1:0]    stk_wdata;

  logic [VER_W-1:0] hidx, hver;
  logic [IW-1:0]    slot;
  logic             hvalid;
  logic             comp_ok;
  logic [KW-1:0]    bit_sel;
  logic [VER_W-1:0] pop_ver;
  logic [IW-1:0]    pop_idx;

  assign accept    = in_tvalid && in_tready;
  assign rd_addr   = IW'(in_tdata[HANDLE_W-1:VER_W]);
  assign stk_raddr = IW'(free_cnt_r - CW'(1));

  assign ver_rd  = tab_rd_r[VER_W-1:0];
  assign mask_rd = tab_rd_r[TW-1:VER_W];

  assign hidx    = hdl_r[HANDLE_W-1:VER_W];
  assign hver    = hdl_r[VER_W-1:0];
  assign slot    = IW'(hidx);
  assign hvalid  = (hver != DEAD_VERSION) && (hidx < VER_W'(fresh_r)) && (ver_rd == hver);
  assign comp_ok = 32'(comp_r) < COMPONENT_KINDS;
  assign bit_sel = comp_ok ? (KW'(1) << comp_r) : '0;
  assign pop_idx = stk_rd_r[SW-1:VER_W];

  // version increment skips the dead code
  always_comb begin
    pop_ver = stk_rd_r[VER_W-1:0] + VER_W'(1);
    if (pop_ver == DEAD_VERSION) begin
      pop_ver = '0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    free_cnt_nxt   = free_cnt_r;
    fresh_nxt      = fresh_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_handle_nxt = out_handle_r;
    out_answer_nxt = out_answer_r;
    out_status_nxt = out_status_r;
    in_tready      = 1'b0;
    tab_we         = 1'b0;
    tab_waddr      = slot;
    ver_wdata      = ver_rd;
    mask_wdata     = mask_rd;
    stk_we         = 1'b0;
    stk_waddr      = IW'(free_cnt_r);
    stk_wdata      = {slot, hver};
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || out_tready) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_handle_nxt = '0;
          out_answer_nxt = 1'b0;
          out_status_nxt = ST_DONE;
          if (req_t'(req_r) == REQ_CREATE) begin
            priority if (free_cnt_r != '0) begin
              free_cnt_nxt   = free_cnt_r - CW'(1);
              tab_we         = 1'b1;
              tab_waddr      = pop_idx;
              ver_wdata      = pop_ver;
              mask_wdata     = '0;
              out_handle_nxt = {VER_W'(pop_idx), pop_ver};
            end else if (fresh_r < CW'(SLOTS)) begin
              fresh_nxt      = fresh_r + CW'(1);
              tab_we         = 1'b1;
              tab_waddr      = IW'(fresh_r);
              ver_wdata      = '0;
              mask_wdata     = '0;
              out_handle_nxt = {VER_W'(fresh_r), VER_W'(0)};
            end else begin
              out_status_nxt = ST_FULL;
            end
          end else if (req_r <= REQ_W'(REQ_HAS)) begin
            if (!hvalid) begin
              out_status_nxt = ST_INVALID;
            end else begin
              unique case (req_t'(req_r))
                REQ_DESTROY: begin
                  if (free_cnt_r < CW'(SLOTS)) begin
                    stk_we       = 1'b1;
                    free_cnt_nxt = free_cnt_r + CW'(1);
                  end
                  tab_we    = 1'b1;
                  ver_wdata = DEAD_VERSION;
                end
                REQ_CHECK: out_answer_nxt = 1'b1;
                REQ_ADD: begin
                  tab_we     = 1'b1;
                  mask_wdata = mask_rd | bit_sel;
                end
                REQ_REMOVE: begin
                  tab_we     = 1'b1;
                  mask_wdata = mask_rd & ~bit_sel;
                end
                REQ_HAS: out_answer_nxt = |(mask_rd & bit_sel);
                default: out_answer_nxt = 1'b0;
              endcase
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_cnt_r  <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_cnt_r  <= free_cnt_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_handle_r <= out_handle_nxt;
    out_answer_r <= out_answer_nxt;
    out_status_r <= out_status_nxt;
    if (accept) begin
      req_r  <= in_tuser;
      hdl_r  <= in_tdata[HANDLE_W-1:0];
      comp_r <= in_tdata[HANDLE_W+COMP_W-1:HANDLE_W];
    end
  end

  // memory ports: read on transfer, write in the update step
  always_ff @(posedge clk) begin
    if (accept) begin
      tab_rd_r <= slot_tab[rd_addr];
    end
    if (tab_we) begin
      slot_tab[tab_waddr] <= {mask_wdata, ver_wdata};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stk_rd_r <= free_stack[stk_raddr];
    end
    if (stk_we) begin
      free_stack[stk_waddr] <= stk_wdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - HANDLE_W - 3)'(0), out_status_r, out_answer_r,
                       out_handle_r};

endmodule

/* rtl/ghalloc_checker.sv */
// port-level checks of the generational handle allocator, bound to the top level
module ghalloc_props (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [ghalloc_pkg::REQ_W-1:0]      in_tuser,
  input logic [ghalloc_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [ghalloc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ghalloc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request at a time: busy in the cycle after a transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a request is in work");

  // failures carry no handle and no answer
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[66:65] != 2'(ST_DONE))
      |-> out_tdata[63:0] == '0 && !out_tdata[64] && out_tdata[66:65] != 2'd3)
    else $error("failed request with payload");

  // a handed-out handle never carries the dead version
  a_live_version: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:0] != DEAD_VERSION)
    else $error("dead version handed out");

endmodule

bind generational_handle_allocator_top ghalloc_props u_ghalloc_props (.*);

/* tb/sv/ghalloc_checker.sv */
// scoreboard for the generational handle allocator: predicts every result and compares it
`timescale 1ns / 100ps
module ghalloc_checker
  import ghalloc_pkg::*;
#(
  parameter int unsigned SLOTS           = 1024,
  parameter int unsigned COMPONENT_KINDS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [REQ_W-1:0]      in_tuser,   // req_type
  input  logic [IN_DATA_W-1:0]  in_tdata,   // handle, component_slot, pad
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // new_handle, answer, status, pad
  output int                    fail_count,
  output int                    pending
);

  localparam int unsigned SIW = $clog2(SLOTS);

  typedef struct packed {
    logic [HANDLE_W-1:0] new_handle;
    logic                answer;
    logic [1:0]          status;
  } alloc_reply_t;

  logic [VER_W-1:0]           slot_ver      [SLOTS];
  logic [COMPONENT_KINDS-1:0] slot_mask     [SLOTS];
  logic [HANDLE_W-1:0]        freed_handles [SLOTS];
  int unsigned                freed_cnt  = 0;
  int unsigned                next_fresh = 0;
  alloc_reply_t               expected_replies[$];
  int                         fails = 0;

  function automatic alloc_reply_t alloc_predict(logic [REQ_W-1:0] req,
                                                 logic [HANDLE_W-1:0] h,
                                                 logic [COMP_W-1:0] comp);
    alloc_reply_t               r;
    logic [31:0]                slot;
    logic [VER_W-1:0]           ver;
    logic [COMPONENT_KINDS-1:0] bit_sel;
    logic                       live;
    r       = '0;
    slot    = h[63:32];
    ver     = h[VER_W-1:0];
    bit_sel = (comp < COMPONENT_KINDS) ? (COMPONENT_KINDS'(1) << comp) : '0;
    live    = 1'b0;
    // never-created slots read as invalid
    if (ver != DEAD_VERSION && slot < next_fresh) live = (slot_ver[SIW'(slot)] == ver);
    case (req)
      REQ_CREATE: begin
        if (freed_cnt > 0) begin
          freed_cnt--;
          slot = freed_handles[SIW'(freed_cnt)][63:32] % SLOTS;
          ver  = freed_handles[SIW'(freed_cnt)][VER_W-1:0] + 1;
          // the all-ones version is reserved for dead slots
          if (ver == DEAD_VERSION) ver = '0;
          slot_ver[SIW'(slot)]  = ver;
          slot_mask[SIW'(slot)] = '0;
          r.new_handle          = {slot, ver};
        end else if (next_fresh < SLOTS) begin
          slot                  = next_fresh;
          slot_ver[SIW'(slot)]  = '0;
          slot_mask[SIW'(slot)] = '0;
          r.new_handle          = {slot, 32'd0};
          next_fresh++;
        end else begin
          r.status = ST_FULL;
        end
      end
      REQ_DESTROY, REQ_CHECK, REQ_ADD, REQ_REMOVE, REQ_HAS: begin
        if (!live) begin
          r.status = ST_INVALID;
        end else begin
          case (req)
            REQ_DESTROY: begin
              if (freed_cnt < SLOTS) begin
                freed_handles[SIW'(freed_cnt)] = h;
                freed_cnt++;
              end
              slot_ver[SIW'(slot)] = DEAD_VERSION;
            end
            REQ_CHECK:  r.answer = 1'b1;
            REQ_ADD:    slot_mask[SIW'(slot)] = slot_mask[SIW'(slot)] | bit_sel;
            REQ_REMOVE: slot_mask[SIW'(slot)] = slot_mask[SIW'(slot)] & ~bit_sel;
            default:    r.answer = |(slot_mask[SIW'(slot)] & bit_sel);
          endcase
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_reply_t want;
    if (!rst_n) begin
      freed_cnt  = 0;
      next_fresh = 0;
      expected_replies.delete();
    end else begin
      // a result leaves only after its request has been registered, so compare first
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected result transfer: new_handle %h", out_tdata[HANDLE_W-1:0]);
          fails++;
        end else begin
          want = expected_replies.pop_front();
          if (out_tdata[HANDLE_W-1:0] !== want.new_handle) begin
            $error("new_handle: expected %h, actual %h", want.new_handle,
                   out_tdata[HANDLE_W-1:0]);
            fails++;
          end
          if (out_tdata[HANDLE_W] !== want.answer) begin
            $error("answer: expected %0d, actual %0d", want.answer, out_tdata[HANDLE_W]);
            fails++;
          end
          if (out_tdata[HANDLE_W+2:HANDLE_W+1] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status,
                   out_tdata[HANDLE_W+2:HANDLE_W+1]);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_replies.insert(expected_replies.size(),
                                alloc_predict(in_tuser, in_tdata[HANDLE_W-1:0],
                                              in_tdata[HANDLE_W+COMP_W-1:HANDLE_W]));
      end
    end
    fail_count <= fails;
    pending    <= expected_replies.size();
  end

endmodule

/* tb/sv/generational_handle_allocator_top_tb.sv */
// testbench top for the generational handle allocator: stimulus, flow control and verdict
`timescale 1ns / 100ps
module generational_handle_allocator_top_tb;
  import ghalloc_pkg::*;

  localparam int unsigned SLOTS           = 1024;
  localparam int unsigned COMPONENT_KINDS = 32;
  localparam int          RANDOM_ITEMS    = 480;
  localparam int          FILL_ITEMS      = 90;
  localparam int          CALM_ITEMS      = 100;
  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam int          STALE_KEEP      = 64;

  typedef struct {
    logic [REQ_W-1:0]    req;
    logic [HANDLE_W-1:0] h;
  } sent_req_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [REQ_W-1:0]      in_tuser   = '0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    fail_count;
  int                    pending;
  bit                    idle_on      = 1'b1;
  bit                    saw_full     = 1'b0;
  int                    stall_left   = 0;
  int                    quiet_cycles = 0;
  logic [HANDLE_W-1:0]   live_handles[$];
  logic [HANDLE_W-1:0]   stale_handles[$];
  sent_req_t             in_flight[$];

  always #1 clk = ~clk;

  generational_handle_allocator_top #(
    .SLOTS          (SLOTS),
    .COMPONENT_KINDS(COMPONENT_KINDS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  ghalloc_checker #(
    .SLOTS          (SLOTS),
    .COMPONENT_KINDS(COMPONENT_KINDS)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // result side back-pressure in random bursts, started only while idle_on is set
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // track live and stale handles from the results to steer later requests
  always @(posedge clk) begin
    sent_req_t sr;
    int        hits[$];
    if (rst_n && out_tvalid && out_tready && in_flight.size() > 0) begin
      sr = in_flight.pop_front();
      if (sr.req == REQ_CREATE) begin
        if (out_tdata[HANDLE_W+2:HANDLE_W+1] == ST_DONE)
          live_handles.insert(live_handles.size(), out_tdata[HANDLE_W-1:0]);
        else if (out_tdata[HANDLE_W+2:HANDLE_W+1] == ST_FULL) saw_full = 1'b1;
      end else if (sr.req == REQ_DESTROY && out_tdata[HANDLE_W+2:HANDLE_W+1] == ST_DONE) begin
        hits = live_handles.find_first_index(x) with (x == sr.h);
        if (hits.size() > 0) live_handles.delete(hits[0]);
        stale_handles.insert(stale_handles.size(), sr.h);
        if (stale_handles.size() > STALE_KEEP) void'(stale_handles.pop_front());
      end
    end
  end

  function automatic logic [HANDLE_W-1:0] handle_of(int unsigned slot, logic [VER_W-1:0] ver);
    return {slot[31:0], ver};
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && live_handles.size() > 0)
      return live_handles[$urandom_range(0, live_handles.size() - 1)];
    if (r < 82 && stale_handles.size() > 0)
      return stale_handles[$urandom_range(0, stale_handles.size() - 1)];
    if (r < 90) return {$urandom, $urandom};
    if (r < 96) return handle_of($urandom_range(0, 40), $urandom_range(0, 3));
    return handle_of($urandom_range(0, SLOTS + 8), DEAD_VERSION);
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] req, input logic [HANDLE_W-1:0] h,
                              input logic [COMP_W-1:0] comp);
    int gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= IN_DATA_W'({comp, h});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    in_flight.insert(in_flight.size(), '{req, h});
  endtask

  task automatic random_request();
    int               r;
    int               cw;
    logic [REQ_W-1:0] req;
    cw = (live_handles.size() < 8) ? 30 : 14;
    r  = $urandom_range(0, 99);
    if (r < cw) req = REQ_CREATE;
    else if (r < cw + 16) req = REQ_DESTROY;
    else if (r < cw + 30) req = REQ_CHECK;
    else if (r < cw + 44) req = REQ_ADD;
    else if (r < cw + 56) req = REQ_REMOVE;
    else if (r < 98) req = REQ_HAS;
    else req = REQ_W'($urandom_range(6, 7));
    send_request(req, pick_handle(), COMP_W'($urandom_range(0, COMPONENT_KINDS - 1)));
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // nothing created yet, unknown request codes, then a small table
    send_request(REQ_CHECK, handle_of(0, 0), 0);
    send_request(3'd6, '1, 5'd31);
    send_request(3'd7, '0, 5'd0);
    repeat (3) send_request(REQ_CREATE, '0, 0);
    send_request(REQ_ADD, handle_of(0, 0), 0);
    send_request(REQ_ADD, handle_of(0, 0), 31);
    send_request(REQ_HAS, handle_of(0, 0), 31);
    send_request(REQ_HAS, handle_of(0, 0), 5);
    send_request(REQ_REMOVE, handle_of(0, 0), 31);
    send_request(REQ_HAS, handle_of(0, 0), 31);
    send_request(REQ_CHECK, handle_of(1, 0), 0);
    send_request(REQ_CHECK, handle_of(1, DEAD_VERSION), 0);
    send_request(REQ_CHECK, handle_of(3, 0), 0);
    send_request(REQ_HAS, handle_of(SLOTS, 0), 0);
    send_request(REQ_CHECK, '1, 0);
    // double destroy, then LIFO reuse with bumped versions
    send_request(REQ_DESTROY, handle_of(1, 0), 0);
    send_request(REQ_DESTROY, handle_of(1, 0), 0);
    send_request(REQ_DESTROY, handle_of(2, 0), 0);
    send_request(REQ_CREATE, '0, 0);
    send_request(REQ_CREATE, '0, 0);
    send_request(REQ_HAS, handle_of(2, 1), 0);
    send_request(REQ_ADD, handle_of(1, 0), 3);
    send_request(REQ_REMOVE, handle_of(0, 0), 0);
    drain();

    for (n = 0; n < RANDOM_ITEMS; n++) random_request();
    drain();

    // a run of creates that drains the free stack and takes fresh slots
    n = 0;
    while (!saw_full && n < FILL_ITEMS) begin
      send_request(REQ_CREATE, {$urandom, $urandom},
                   COMP_W'($urandom_range(0, COMPONENT_KINDS - 1)));
      n++;
    end
    repeat (3) send_request(REQ_CREATE, {$urandom, $urandom}, 0);

    idle_on = 1'b0;
    for (n = 0; n < CALM_ITEMS; n++) random_request();
    drain();
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ghalloc_pkg.sv
rtl/generational_handle_allocator_top.sv
rtl/ghalloc_checker.sv
tb/sv/ghalloc_checker.sv
tb/sv/generational_handle_allocator_top_tb.sv
